// ===== hdl/keyed_record_table_unit_macros.svh =====
// assertion macros for the keyed record table unit
// taken in by the top level; needs no other file
`ifndef KEYED_RECORD_TABLE_UNIT_MACROS_SVH
`define KEYED_RECORD_TABLE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// checked only while out of reset
`define KRT_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("keyed record table check failed");
// checked at every edge, reset included
`define KRT_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("keyed record table check failed");
`else
`define KRT_ASSERT(name, clk, rst_n, prop)
`define KRT_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// ===== hdl/krt_pkg.sv =====
// shared types and constants of the keyed record table unit
// used by the interfaces, controller, datapath and top level
package krt_pkg;

    localparam int SLOTS_DEF      = 64;
    localparam int NAME_BYTES_DEF = 8;

    localparam int KEY_W    = 27;
    localparam int NAME_W   = 64;
    localparam int AGE_W    = 7;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_PRESENT   = 3'd2,
        ST_DELETED   = 3'd3,
        ST_CANCELLED = 3'd4,
        ST_NOT_FOUND = 3'd5
    } status_t;

    typedef enum logic [2:0]
    {
        S_CLEAR  = 3'd0,
        S_IDLE   = 3'd1,
        S_SCAN   = 3'd2,
        S_DRAIN  = 3'd3,
        S_FINISH = 3'd4
    } state_t;

    // controller to datapath
    typedef struct packed
    {
        logic in_ready;
        logic clr_wr;
        logic rd;
        logic cnt_inc;
        logic trk_clr;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed
    {
        logic req_valid;
        logic cnt_last;
        logic out_free;
    } sts_t;

endpackage

// ===== hdl/krt_if.sv =====
// request and response channels of the keyed record table unit
// depends on krt_pkg for field widths
interface krt_req_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [krt_pkg::KEY_W-1:0]     key;
    logic [krt_pkg::NAME_W-1:0]    name_bytes;
    logic [krt_pkg::AGE_W-1:0]     age;
    logic                          confirm;

    modport source
    (
        output valid, operation, key, name_bytes, age, confirm,
        input  ready
    );
    modport sink
    (
        input  valid, operation, key, name_bytes, age, confirm,
        output ready
    );
endinterface

interface krt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [krt_pkg::STATUS_W-1:0]  status;
    logic [krt_pkg::SLOT_W-1:0]    slot;
    logic [krt_pkg::KEY_W-1:0]     found_key;
    logic [krt_pkg::NAME_W-1:0]    found_name;
    logic [krt_pkg::AGE_W-1:0]     found_age;

    modport source
    (
        output valid, status, slot, found_key, found_name, found_age,
        input  ready
    );
    modport sink
    (
        input  valid, status, slot, found_key, found_name, found_age,
        output ready
    );
endinterface

// ===== hdl/krt_ctrl.sv =====
// sequencer of the keyed record table: clear pass, scan, finish
// depends on krt_pkg for the state, command and status types
module krt_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  krt_pkg::sts_t sts,
    output krt_pkg::cmd_t cmd
);

    krt_pkg::state_t state_reg;
    krt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= krt_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            krt_pkg::S_CLEAR:
            begin
                if (sts.cnt_last)
                begin
                    state_next = krt_pkg::S_IDLE;
                end
            end
            krt_pkg::S_IDLE:
            begin
                if (sts.req_valid)
                begin
                    state_next = krt_pkg::S_SCAN;
                end
            end
            krt_pkg::S_SCAN:
            begin
                if (sts.cnt_last)
                begin
                    state_next = krt_pkg::S_DRAIN;
                end
            end
            krt_pkg::S_DRAIN:
            begin
                state_next = krt_pkg::S_FINISH;
            end
            krt_pkg::S_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = krt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = krt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            krt_pkg::S_CLEAR:
            begin
                cmd.clr_wr  = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            krt_pkg::S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.trk_clr  = 1'b1;
            end
            krt_pkg::S_SCAN:
            begin
                cmd.rd      = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            krt_pkg::S_DRAIN:
            begin
                cmd = '0;
            end
            krt_pkg::S_FINISH:
            begin
                cmd.finish = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hdl/krt_dp.sv =====
// datapath of the keyed record table: record memory, slot counter,
// compare stage, free and match trackers, output register; uses krt_pkg
module krt_dp
#(
    parameter int SLOTS      = krt_pkg::SLOTS_DEF,
    parameter int NAME_BYTES = krt_pkg::NAME_BYTES_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  krt_pkg::cmd_t cmd,
    output krt_pkg::sts_t sts,
    krt_req_if.sink       req,
    krt_rsp_if.source     rsp
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int KW    = krt_pkg::KEY_W;
    localparam int NW    = krt_pkg::NAME_W;
    localparam int SNW   = 8 * NAME_BYTES;
    localparam int AW    = krt_pkg::AGE_W;
    localparam int OSW   = krt_pkg::SLOT_W;
    localparam int REC_W = 1 + KW + SNW + AW;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // record word: live bit, key, name, age
    logic [REC_W-1:0] rec_mem_reg [SLOTS];
    logic [REC_W-1:0] rd_data_reg;

    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;
    logic             cmp_en_reg;
    logic [IDX_W-1:0] cmp_idx_reg;

    krt_pkg::op_t     op_reg;
    logic [KW-1:0]    key_reg;
    logic [SNW-1:0]   name_reg;
    logic [AW-1:0]    age_reg;
    logic             confirm_reg;

    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic             hit_found_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [KW-1:0]    hit_key_reg;
    logic [SNW-1:0]   hit_name_reg;
    logic [AW-1:0]    hit_age_reg;

    logic             out_valid_reg;
    logic             out_valid_next;
    krt_pkg::status_t out_status_reg;
    logic [OSW-1:0]   out_slot_reg;
    logic [KW-1:0]    out_key_reg;
    logic [NW-1:0]    out_name_reg;
    logic [AW-1:0]    out_age_reg;

    logic             rd_live;
    logic [KW-1:0]    rd_key;
    logic [SNW-1:0]   rd_name;
    logic [AW-1:0]    rd_age;
    logic             free_now;
    logic             hit_now;
    logic             req_fire;

    logic             ins_store;
    logic             del_free;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [REC_W-1:0] mem_wdata;

    krt_pkg::status_t res_status;
    logic [IDX_W-1:0] res_idx;
    logic             res_with_slot;
    logic             res_with_rec;

    assign req.ready     = cmd.in_ready;
    assign req_fire      = req.valid && cmd.in_ready;

    assign sts.req_valid = req.valid;
    assign sts.cnt_last  = (cnt_reg == LAST_IDX);
    assign sts.out_free  = !out_valid_reg || rsp.ready;

    // slot counter, wraps to zero after the last slot
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_inc)
        begin
            cnt_next = (cnt_reg == LAST_IDX) ? '0 : cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            cmp_en_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            cmp_en_reg <= cmd.rd;
        end
    end

    // record memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rec_mem_reg[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= rec_mem_reg[cnt_reg];
        end
        cmp_idx_reg <= cnt_reg;
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg      <= krt_pkg::op_t'(req.operation);
            key_reg     <= req.key;
            name_reg    <= req.name_bytes[SNW-1:0];
            age_reg     <= req.age;
            confirm_reg <= req.confirm;
        end
    end

    assign rd_live = rd_data_reg[REC_W-1];
    assign rd_key  = rd_data_reg[REC_W-2 -: KW];
    assign rd_name = rd_data_reg[AW +: SNW];
    assign rd_age  = rd_data_reg[AW-1:0];

    // first free slot and first live match, in slot order
    assign free_now = cmp_en_reg && !rd_live && !free_found_reg;
    assign hit_now  = cmp_en_reg && rd_live && (rd_key == key_reg) && !hit_found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_found_reg <= 1'b0;
            hit_found_reg  <= 1'b0;
        end
        else if (cmd.trk_clr)
        begin
            free_found_reg <= 1'b0;
            hit_found_reg  <= 1'b0;
        end
        else
        begin
            if (free_now)
            begin
                free_found_reg <= 1'b1;
            end
            if (hit_now)
            begin
                hit_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (free_now)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
        if (hit_now)
        begin
            hit_idx_reg  <= cmp_idx_reg;
            hit_key_reg  <= rd_key;
            hit_name_reg <= rd_name;
            hit_age_reg  <= rd_age;
        end
    end

    // outcome of the scan
    always_comb
    begin
        res_status    = krt_pkg::ST_NOT_FOUND;
        res_idx       = hit_idx_reg;
        res_with_slot = 1'b0;
        res_with_rec  = 1'b0;
        ins_store     = 1'b0;
        del_free      = 1'b0;
        if (op_reg == krt_pkg::OP_INSERT)
        begin
            if (!free_found_reg)
            begin
                res_status = krt_pkg::ST_FULL;
            end
            else if (hit_found_reg)
            begin
                res_status    = krt_pkg::ST_PRESENT;
                res_with_slot = 1'b1;
                res_with_rec  = 1'b1;
            end
            else
            begin
                res_status    = krt_pkg::ST_INSERTED;
                res_idx       = free_idx_reg;
                res_with_slot = 1'b1;
                ins_store     = 1'b1;
            end
        end
        else if (hit_found_reg)
        begin
            res_status    = confirm_reg ? krt_pkg::ST_DELETED : krt_pkg::ST_CANCELLED;
            res_with_slot = 1'b1;
            res_with_rec  = 1'b1;
            del_free      = confirm_reg;
        end
    end

    // clear pass and freeing both write a dead word
    assign mem_we    = cmd.clr_wr || (cmd.finish && (ins_store || del_free));
    assign mem_waddr = cmd.clr_wr ? cnt_reg : res_idx;
    assign mem_wdata = (!cmd.clr_wr && ins_store) ? {1'b1, key_reg, name_reg, age_reg} : '0;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_status_reg <= res_status;
            out_slot_reg   <= res_with_slot ? OSW'(res_idx) : '0;
            out_key_reg    <= res_with_rec ? hit_key_reg : '0;
            out_name_reg   <= res_with_rec ? NW'(hit_name_reg) : '0;
            out_age_reg    <= res_with_rec ? hit_age_reg : '0;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.slot       = out_slot_reg;
    assign rsp.found_key  = out_key_reg;
    assign rsp.found_name = out_name_reg;
    assign rsp.found_age  = out_age_reg;

endmodule

// ===== hdl/keyed_record_table_unit.sv =====
// top level of the keyed record table unit
// depends on krt_pkg, krt_if, krt_ctrl, krt_dp and the assertion macros
//
//  channel  dir  word
//  -------  ---  ----------------------------------------------------
//  req      in   operation, key, name_bytes, age, confirm
//  rsp      out  status, slot, found_key, found_name, found_age
//
// requests are served one at a time: the scan reads one record per cycle
// through the single read port of the record memory; drain completes the
// last compare; finish decides, writes back and loads the output register
// after reset a clearing pass over all SLOTS slots marks every slot free;
// req.ready stays low meanwhile
// a request is taken while the previous response waits; the finish step
// holds until the output register is free
`include "keyed_record_table_unit_macros.svh"

module keyed_record_table_unit
#(
    parameter int SLOTS      = krt_pkg::SLOTS_DEF,
    parameter int NAME_BYTES = krt_pkg::NAME_BYTES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    krt_req_if.sink   req,
    krt_rsp_if.source rsp
);

    krt_pkg::cmd_t cmd;
    krt_pkg::sts_t sts;

    krt_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    krt_dp
    #(
        .SLOTS      (SLOTS),
        .NAME_BYTES (NAME_BYTES)
    )
    u_dp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts),
        .req   (req),
        .rsp   (rsp)
    );

    `KRT_ASSERT(a_one_at_a_time, clk, rst_n, req.valid && req.ready |=> !req.ready)
    `KRT_ASSERT(a_no_read_on_clear, clk, rst_n, !(cmd.rd && cmd.clr_wr))
    `KRT_ASSERT(a_finish_loads_output, clk, rst_n, cmd.finish |=> rsp.valid)
    `KRT_ASSERT_ALWAYS(a_quiet_in_reset, clk, !rst_n |-> !req.ready && !rsp.valid)

endmodule

// ===== test/keyed_record_table_unit_tb.sv =====
// testbench for keyed_record_table_unit: inserts, duplicates, full table, deletes and cancels
// depends on krt_pkg, krt_if and the keyed_record_table_unit rtl; checks every response word
// against a table predictor kept here, under random idling and output backpressure
module keyed_record_table_unit_tb;

    localparam int SLOTS      = krt_pkg::SLOTS_DEF;
    localparam int KW         = krt_pkg::KEY_W;
    localparam int AW         = krt_pkg::AGE_W;
    localparam int KEY_MAX    = 99999999;
    localparam int RUN_LIMIT  = 1000000;
    localparam int DRAIN_WAIT = SLOTS + 8;

    typedef struct
    {
        krt_pkg::status_t                status;
        logic [krt_pkg::SLOT_W-1:0]      slot;
        logic [krt_pkg::KEY_W-1:0]       key;
        logic [krt_pkg::NAME_W-1:0]      name;
        logic [krt_pkg::AGE_W-1:0]       age;
    } rsp_word_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b1;

    krt_req_if req_ch();
    krt_rsp_if rsp_ch();

    keyed_record_table_unit u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #2 clk = ~clk;

    // table as the block should hold it
    bit                          live       [SLOTS];
    logic [krt_pkg::KEY_W-1:0]   stored_key [SLOTS];
    logic [krt_pkg::NAME_W-1:0]  stored_name[SLOTS];
    logic [krt_pkg::AGE_W-1:0]   stored_age [SLOTS];

    rsp_word_t                   pending_rsp[$];
    rsp_word_t                   oldest;
    logic [krt_pkg::KEY_W-1:0]   key_pool[32];

    int errors         = 0;
    int requests_sent  = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int rsp_hold       = 0;
    int outcome_count[6];

    function automatic int lowest_free_slot();
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!live[i])
                return i;
        end
        return -1;
    endfunction

    function automatic int find_live_key(logic [krt_pkg::KEY_W-1:0] k);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (live[i] && stored_key[i] == k)
                return i;
        end
        return -1;
    endfunction

    // applies one request to the table and returns the response word it must give
    function automatic rsp_word_t apply_to_table(krt_pkg::op_t op,
                                                 logic [krt_pkg::KEY_W-1:0] k,
                                                 logic [krt_pkg::NAME_W-1:0] nm,
                                                 logic [krt_pkg::AGE_W-1:0] ag,
                                                 bit conf);
        rsp_word_t r;
        int        free_idx;
        int        hit;
        r.status = krt_pkg::ST_NOT_FOUND;
        r.slot   = '0;
        r.key    = '0;
        r.name   = '0;
        r.age    = '0;
        hit = find_live_key(k);
        if (op == krt_pkg::OP_INSERT)
        begin
            free_idx = lowest_free_slot();
            if (free_idx < 0)
                r.status = krt_pkg::ST_FULL;
            else if (hit >= 0)
                r.status = krt_pkg::ST_PRESENT;
            else
            begin
                r.status              = krt_pkg::ST_INSERTED;
                r.slot                = free_idx[krt_pkg::SLOT_W-1:0];
                live[free_idx]        = 1'b1;
                stored_key[free_idx]  = k;
                stored_name[free_idx] = nm;
                stored_age[free_idx]  = ag;
            end
        end
        else if (hit >= 0)
            r.status = conf ? krt_pkg::ST_DELETED : krt_pkg::ST_CANCELLED;
        if (r.status == krt_pkg::ST_PRESENT || r.status == krt_pkg::ST_DELETED ||
            r.status == krt_pkg::ST_CANCELLED)
        begin
            r.slot = hit[krt_pkg::SLOT_W-1:0];
            r.key  = stored_key[hit];
            r.name = stored_name[hit];
            r.age  = stored_age[hit];
            if (r.status == krt_pkg::ST_DELETED)
                live[hit] = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [krt_pkg::NAME_W-1:0] random_name();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [krt_pkg::KEY_W-1:0] random_key();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return '0;
        if (pick < 10)
            return KW'(KEY_MAX);
        if (pick < 60)
            return key_pool[$urandom_range(31)];
        return KW'($urandom_range(KEY_MAX));
    endfunction

    function automatic logic [krt_pkg::KEY_W-1:0] live_key_or_random();
        int start;
        int idx;
        start = $urandom_range(SLOTS-1);
        for (int i = 0; i < SLOTS; i++)
        begin
            idx = (start + i) % SLOTS;
            if (live[idx])
                return stored_key[idx];
        end
        return random_key();
    endfunction

    task automatic send_request(krt_pkg::op_t op, logic [krt_pkg::KEY_W-1:0] k,
                                logic [krt_pkg::NAME_W-1:0] nm,
                                logic [krt_pkg::AGE_W-1:0] ag, bit conf);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= op;
        req_ch.key        <= k;
        req_ch.name_bytes <= nm;
        req_ch.age        <= ag;
        req_ch.confirm    <= conf;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_rsp.push_back(apply_to_table(op, k, nm, ag, conf));
        requests_sent++;
    endtask

    task automatic random_request(int insert_pct);
        logic [krt_pkg::KEY_W-1:0] k;
        if ($urandom_range(99) < insert_pct)
        begin
            k = ($urandom_range(99) < 20) ? live_key_or_random() : random_key();
            send_request(krt_pkg::OP_INSERT, k, random_name(), AW'($urandom_range(127)),
                         1'($urandom_range(1)));
        end
        else
        begin
            k = ($urandom_range(99) < 75) ? live_key_or_random() : random_key();
            send_request(krt_pkg::OP_DELETE, k, random_name(), AW'($urandom_range(127)),
                         $urandom_range(99) < 70);
        end
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_request(krt_pkg::OP_DELETE, 27'd5, '0, 7'd0, 1'b1);
        send_request(krt_pkg::OP_INSERT, 27'd0, '1, 7'd127, 1'b1);
        send_request(krt_pkg::OP_INSERT, KW'(KEY_MAX), '0, 7'd0, 1'b0);
        send_request(krt_pkg::OP_INSERT, 27'd0, 64'h0123_4567_89ab_cdef, 7'd33, 1'b0);
        // delete ignores name and age; confirm low keeps the record
        send_request(krt_pkg::OP_DELETE, KW'(KEY_MAX), '1, 7'd127, 1'b0);
        send_request(krt_pkg::OP_DELETE, KW'(KEY_MAX), 64'h5a5a_5a5a_5a5a_5a5a, 7'd9, 1'b1);
        send_request(krt_pkg::OP_DELETE, KW'(KEY_MAX), '0, 7'd0, 1'b1);
        send_request(krt_pkg::OP_INSERT, 27'd12345, 64'h6a6f_686e_2073_6d69, 7'd42, 1'b1);
        send_request(krt_pkg::OP_INSERT, 27'h2aa_aaaa, 64'haaaa_aaaa_aaaa_aaaa, 7'h55, 1'b0);
        send_request(krt_pkg::OP_INSERT, 27'h555_5555, 64'h5555_5555_5555_5555, 7'h2a, 1'b1);
        send_request(krt_pkg::OP_DELETE, 27'd0, '0, 7'd0, 1'b1);
        send_request(krt_pkg::OP_INSERT, 27'd7, 64'h0000_0000_0000_0073, 7'd1, 1'b0);
        send_request(krt_pkg::OP_DELETE, 27'd12345, '0, 7'd0, 1'b0);
        send_request(krt_pkg::OP_INSERT, 27'd12345, '1, 7'd0, 1'b1);
        send_request(krt_pkg::OP_DELETE, 27'd12345, '0, 7'd0, 1'b1);
        send_request(krt_pkg::OP_DELETE, 27'h2aa_aaaa, '0, 7'd0, 1'b1);
        send_request(krt_pkg::OP_INSERT, 27'h2aa_aaaa, '0, 7'd127, 1'b0);
    endtask

    task automatic test_fill_to_full();
        int                         guard;
        logic [krt_pkg::KEY_W-1:0]  k;
        send_idle_pct  = 22;
        recv_stall_pct = 22;
        guard = 0;
        while (lowest_free_slot() >= 0 && guard < 4*SLOTS)
        begin
            send_request(krt_pkg::OP_INSERT, KW'($urandom_range(KEY_MAX)), random_name(),
                         AW'($urandom_range(127)), 1'($urandom_range(1)));
            guard++;
        end
        // a full table wins over a duplicate key
        send_request(krt_pkg::OP_INSERT, stored_key[5], random_name(), 7'd3, 1'b0);
        send_request(krt_pkg::OP_INSERT, random_key(), random_name(), 7'd4, 1'b1);
        k = stored_key[SLOTS-1];
        send_request(krt_pkg::OP_DELETE, k, '0, 7'd0, 1'b0);
        send_request(krt_pkg::OP_INSERT, random_key(), random_name(), 7'd5, 1'b0);
        send_request(krt_pkg::OP_DELETE, k, '0, 7'd0, 1'b1);
        send_request(krt_pkg::OP_INSERT, stored_key[3], random_name(), 7'd6, 1'b0);
        send_request(krt_pkg::OP_INSERT, KW'($urandom_range(KEY_MAX)), random_name(),
                     7'd7, 1'b0);
        send_request(krt_pkg::OP_INSERT, KW'($urandom_range(KEY_MAX)), random_name(),
                     7'd8, 1'b0);
        for (int i = 0; i < 40; i++)
            send_request(krt_pkg::OP_DELETE, live_key_or_random(), '0, 7'd0, 1'b1);
    endtask

    // insert bias swings so the table alternately fills up and drains
    task automatic test_random_phase(int idle_pct, int stall_pct, int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
            random_request(((i / 60) % 2 == 0) ? 80 : 30);
    endtask

    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rsp_hold       = 600;
        for (int i = 0; i < 8; i++)
            random_request(60);
    endtask

    function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            errors++;
        end
    endfunction

    // response sink; a hold request from a test overrides random stalls
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_hold > 0)
            begin
                rsp_hold--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: response word with none expected, actual status %0d slot %0d",
                         $time, rsp_ch.status, rsp_ch.slot);
                errors++;
            end
            else
            begin
                oldest = pending_rsp.pop_front();
                check_field("status", 64'(oldest.status), 64'(rsp_ch.status));
                check_field("slot", 64'(oldest.slot), 64'(rsp_ch.slot));
                check_field("found_key", 64'(oldest.key), 64'(rsp_ch.found_key));
                check_field("found_name", oldest.name, rsp_ch.found_name);
                check_field("found_age", 64'(oldest.age), 64'(rsp_ch.found_age));
                outcome_count[oldest.status]++;
            end
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d responses outstanding",
                 cycles, pending_rsp.size());
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rst_n             <= 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.operation  = krt_pkg::OP_INSERT;
        req_ch.key        = '0;
        req_ch.name_bytes = '0;
        req_ch.age        = '0;
        req_ch.confirm    = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            live[i] = 1'b0;
        for (int i = 0; i < 32; i++)
            key_pool[i] = KW'($urandom_range(KEY_MAX));
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_fill_to_full();
        test_random_phase(0, 0, 250);
        test_random_phase(57, 0, 250);
        test_output_backpressure();
        test_random_phase(0, 57, 250);
        test_random_phase(22, 22, 250);

        req_ch.valid <= 1'b0;
        wait (pending_rsp.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d requests: %0d inserted, %0d table full, %0d duplicate key,",
                 requests_sent, outcome_count[krt_pkg::ST_INSERTED],
                 outcome_count[krt_pkg::ST_FULL], outcome_count[krt_pkg::ST_PRESENT]);
        $display("%0d deleted, %0d cancelled, %0d not found; %0d mismatches",
                 outcome_count[krt_pkg::ST_DELETED], outcome_count[krt_pkg::ST_CANCELLED],
                 outcome_count[krt_pkg::ST_NOT_FOUND], errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== keyed_record_table_unit.f =====
+incdir+hdl
hdl/krt_pkg.sv
hdl/krt_if.sv
hdl/krt_ctrl.sv
hdl/krt_dp.sv
hdl/keyed_record_table_unit.sv
test/keyed_record_table_unit_tb.sv
